// ===== rtl/tsda_pkg.sv =====
// Package: shared types and constants for the tile shape dedup allocator.
package tsda_pkg;
   localparam int unsigned EntriesDefault = 256;
   localparam int unsigned ShapeWidth = 64;

   typedef enum logic [1:0] {
      CMD_AGE   = 2'd0,
      CMD_PROBE = 2'd1,
      CMD_ALLOC = 2'd2,
      CMD_ALT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT   = 3'd0,
      ST_ALLOC = 3'd1,
      ST_MISS  = 3'd2,
      ST_FULL  = 3'd3,
      ST_AGED  = 3'd4
   } status_type;

   // Flag bits: here, prev, old
   localparam logic [2:0] FlagHere = 3'b100;
   localparam logic [2:0] ResetFlagsFirst = 3'b011;

   // Control passed from sequencer to every cell
   typedef struct packed {
      logic age;    // age all flags this cycle
      logic rotate; // shift ring one place
      logic hit;    // set here flag at head
      logic write;  // write shape and here flag at head
   } ctl_type;
endpackage

// ===== rtl/tsda_cell.sv =====
// One cell of the entry ring: holds a shape and its age flags.
module tsda_cell
   import tsda_pkg::*;
#(
   parameter logic [2:0] RESET_FLAGS = 3'b000,
   parameter bit IS_HEAD = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   input  logic [ShapeWidth-1:0] new_shape,
   input  logic [ShapeWidth-1:0] prev_shape,
   input  logic [2:0]            prev_flags,
   output logic [ShapeWidth-1:0] shape,
   output logic [2:0]            flags
);
   logic [ShapeWidth-1:0] shape_ff, shape_in;
   logic [2:0]            flags_ff, flags_in;

   // Select next contents: age, rotate in from neighbor, or update at head
   always_comb begin
      shape_in = shape_ff;
      flags_in = flags_ff;
      if (ctl.age) begin
         flags_in = {1'b0, flags_ff[2], flags_ff[1] | flags_ff[0]};
      end else if (ctl.rotate) begin
         shape_in = prev_shape;
         flags_in = prev_flags;
      end else if (IS_HEAD && ctl.write) begin
         shape_in = new_shape;
         flags_in = flags_ff | FlagHere;
      end else if (IS_HEAD && ctl.hit) begin
         flags_in = flags_ff | FlagHere;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= '0;
         flags_ff <= RESET_FLAGS;
      end else begin
         shape_ff <= shape_in;
         flags_ff <= flags_in;
      end
   end

   assign shape = shape_ff;
   assign flags = flags_ff;
endmodule

// ===== rtl/tile_shape_dedup_allocator.sv =====
// Top level: ring of entry cells and a sequencer that scans it.
//
//  channel | dir | tdata (low bit first)        | handshake
//  req     | in  | command[1:0], shape[65:2]    | tvalid/tready
//  rsp     | out | status[2:0], index[10:3]     | tvalid/tready
//
// Entries circulate through the ring; the head cell is compared and updated.
// Lookup: the ring rotates once round until the scan is home, then the reply
// state loads the result; a hit holds the ring while it sets the here flag.
// Allocate miss: a second pass rotates to the free entry, holds to write it,
// returns home and loads the result. Age: result loads at the transfer.
// One item at a time; req_tready stays low while a result waits, so a stalled
// output stalls the input. Reset is synchronous, no clearing pass.
module tile_shape_dedup_allocator
   import tsda_pkg::*;
#(
   parameter int unsigned ENTRIES = EntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // command[1:0], shape[65:2], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // status[2:0], index[10:3], zero pad
);
   localparam int unsigned IW = $clog2(ENTRIES);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REPLY} state_type;

   state_type             state_ff;
   logic                  alloc_ff, found_ff, free_ff, wpass_ff;
   logic [ShapeWidth-1:0] shape_ff;
   logic [IW:0]           cnt_ff;
   logic [IW-1:0]         hit_idx_ff, free_idx_ff;
   logic [2:0]            status_ff;
   logic [7:0]            index_ff;
   logic                  rsp_valid_ff;

   logic [ShapeWidth-1:0] shp [ENTRIES];
   logic [2:0]            flg [ENTRIES];
   ctl_type               ctl;
   logic                  head_match, head_free, at_home;
   logic                  do_hit, do_write;
   logic [IW-1:0]         pos;

   // Head entry position: entries rotate one place per cycle in a scan, unless held
   assign pos = cnt_ff[IW-1:0];
   assign at_home = (cnt_ff == (IW+1)'(ENTRIES));
   assign head_match = (flg[0] != 3'b000) && (shp[0] == shape_ff);
   assign head_free = (flg[0][2:1] == 2'b00);

   // Hit on the lookup pass, write on the allocate pass
   assign do_hit   = !at_home && !wpass_ff && !found_ff && head_match;
   assign do_write = !at_home && wpass_ff && !found_ff && (pos == free_idx_ff);

   // Build the ring of cells
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      tsda_cell #(
         .RESET_FLAGS((g == 0) ? ResetFlagsFirst : 3'b000),
         .IS_HEAD    (g == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_shape (shape_ff),
         .prev_shape(shp[(g + 1) % ENTRIES]),
         .prev_flags(flg[(g + 1) % ENTRIES]),
         .shape     (shp[g]),
         .flags     (flg[g])
      );
   end

   // Cell control: age on request; scan updates head as its entry passes, else rotate
   always_comb begin
      ctl = '0;
      if (state_ff == S_IDLE && req_tvalid && !rsp_valid_ff &&
          cmd_type'(req_tdata[1:0]) == CMD_AGE) begin
         ctl.age = 1'b1;
      end
      if (state_ff == S_SCAN && !at_home) begin
         if (do_hit) begin
            ctl.hit = 1'b1;
         end else if (do_write) begin
            ctl.write = 1'b1;
         end else begin
            ctl.rotate = 1'b1;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // Sequencer: scan records hit and free slot, then a write pass on an allocate miss
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         wpass_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  shape_ff <= req_tdata[65:2];
                  alloc_ff <= req_tdata[1];
                  if (cmd_type'(req_tdata[1:0]) == CMD_AGE) begin
                     status_ff    <= ST_AGED;
                     index_ff     <= '0;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     cnt_ff   <= '0;
                     found_ff <= 1'b0;
                     free_ff  <= 1'b0;
                     wpass_ff <= 1'b0;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (at_home) begin
                  state_ff <= S_REPLY;
                  cnt_ff   <= '0;
               end else if (do_hit) begin
                  // hold rotation this cycle while setting here flag
                  found_ff   <= 1'b1;
                  hit_idx_ff <= pos;
               end else if (do_write) begin
                  // hold rotation this cycle while writing the free entry
                  found_ff <= 1'b1;
               end else begin
                  if (!wpass_ff && !free_ff && head_free) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= pos;
                  end
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_REPLY: begin
               // Report, or start the pass that writes the free slot
               if (wpass_ff) begin
                  status_ff    <= ST_ALLOC;
                  index_ff     <= 8'(free_idx_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (found_ff) begin
                  status_ff    <= ST_HIT;
                  index_ff     <= 8'(hit_idx_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (!alloc_ff) begin
                  status_ff    <= ST_MISS;
                  index_ff     <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (!free_ff) begin
                  status_ff    <= ST_FULL;
                  index_ff     <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  wpass_ff <= 1'b1;
                  found_ff <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= S_SCAN;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, index_ff, status_ff};

`ifndef SYNTHESIS
   // Hold a waiting result unchanged until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata));
   // Accept no input while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid);
   // Report only defined status codes
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_AGED);
`endif
endmodule

// ===== tb/sv/tb_tile_shape_dedup_allocator.sv =====
// Testbench for the tile shape dedup allocator: random and directed shape traffic.
module tb_tile_shape_dedup_allocator;
   import tsda_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NumEntries = 256;

   typedef struct packed {
      logic [63:0] shape;
      cmd_type     cmd;
   } shape_req_t;

   typedef struct packed {
      logic [7:0]  index;
      status_type  status;
   } shape_rsp_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;  // command[1:0], shape[65:2], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;  // status[2:0], index[10:3], zero pad

   tile_shape_dedup_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predictor state
   logic [63:0] shape_mirror [NumEntries];
   logic [2:0]  flag_mirror [NumEntries];

   shape_req_t pending_reqs [$];
   shape_rsp_t expected_rsps [$];
   int unsigned mismatch_count = 0;
   bit no_idle = 0;
   bit drain_pause = 0;
   bit stall_long = 0;
   bit stim_done = 0;

   // Model one accepted command against the mirrored table.
   function automatic shape_rsp_t predict_lookup(shape_req_t r);
      shape_rsp_t res;
      res.status = ST_AGED;
      res.index = '0;
      if (r.cmd == CMD_AGE) begin
         for (int i = 0; i < NumEntries; i++)
            flag_mirror[i] = (flag_mirror[i] & 3'b001) | (flag_mirror[i] >> 1);
         return res;
      end
      for (int i = 0; i < NumEntries; i++) begin
         if (flag_mirror[i] != 3'b000 && shape_mirror[i] == r.shape) begin
            flag_mirror[i] = flag_mirror[i] | FlagHere;
            res.status = ST_HIT;
            res.index = i[7:0];
            return res;
         end
      end
      if (!r.cmd[1]) begin
         res.status = ST_MISS;
         return res;
      end
      for (int i = 0; i < NumEntries; i++) begin
         if ((flag_mirror[i] & 3'b110) == 3'b000) begin
            shape_mirror[i] = r.shape;
            flag_mirror[i] = flag_mirror[i] | FlagHere;
            res.status = ST_ALLOC;
            res.index = i[7:0];
            return res;
         end
      end
      res.status = ST_FULL;
      return res;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Driver: offer queued items with random gaps.
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            void'(pending_reqs.pop_front());
            expected_rsps.push_back(predict_lookup(shape_req_t'(req_tdata[65:0])));
         end
         if (req_tvalid && !req_tready) begin
            // hold offered item
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 0;
         end else if (drain_pause || pending_reqs.size() == 0) begin
            req_tvalid <= 0;
         end else begin
            req_tvalid <= 1;
            req_tdata <= {6'd0, pending_reqs[0]};
            if (!no_idle && $urandom_range(0, 3) == 0)
               send_gap <= $urandom_range(1, 3);
         end
      end
   end

   // Receiver: random backpressure plus one long hold-off.
   int unsigned recv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (stall_long) begin
         rsp_tready <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
         if (!no_idle && $urandom_range(0, 3) == 0)
            recv_gap <= $urandom_range(1, 3);
      end
   end

   // Monitor: compare each result with the oldest expectation.
   always @(posedge clock) begin
      shape_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = shape_rsp_t'(rsp_tdata[10:0]);
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result status=%0d index=%0d", got.status, got.index);
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status || got.index !== want.index) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status=%0d index=%0d, got status=%0d index=%0d",
                           want.status, want.index, got.status, got.index);
            end
         end
      end
   end

   task automatic add_item(cmd_type c, logic [63:0] s);
      shape_req_t r;
      r.cmd = c;
      r.shape = s;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [63:0] rand_shape();
      return {$urandom(), $urandom()};
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus
   initial begin
      logic [63:0] pool [16];
      int unsigned pick;
      for (int i = 0; i < NumEntries; i++) begin
         shape_mirror[i] = '0;
         flag_mirror[i] = 3'b000;
      end
      flag_mirror[0] = ResetFlagsFirst;
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: zero shape hits entry 0, extremes, all commands
      add_item(CMD_PROBE, 64'd0);
      add_item(CMD_PROBE, '1);
      add_item(CMD_ALLOC, '1);
      add_item(CMD_ALT, 64'h5555_5555_5555_5555);
      add_item(CMD_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA);
      add_item(CMD_PROBE, '1);
      add_item(CMD_ALLOC, 64'd0);
      add_item(CMD_AGE, 64'd0);
      add_item(CMD_PROBE, 64'hAAAA_AAAA_AAAA_AAAA);
      add_item(CMD_AGE, '1);
      add_item(CMD_AGE, 64'd0);
      add_item(CMD_ALLOC, 64'h0123_4567_89AB_CDEF);
      add_item(CMD_PROBE, 64'h0123_4567_89AB_CDEF);
      // long receiver hold-off while sender keeps offering
      stall_long = 1;
      repeat (3000) @(posedge clock);
      stall_long = 0;
      wait_drained();

      // fill the table to force full
      for (int i = 0; i < NumEntries + 4; i++)
         add_item(i[0] ? CMD_ALT : CMD_ALLOC, rand_shape());
      add_item(CMD_PROBE, rand_shape());
      add_item(CMD_AGE, '0);
      add_item(CMD_ALLOC, rand_shape());
      add_item(CMD_AGE, '0);
      add_item(CMD_ALLOC, rand_shape());
      // wait until all results are back, then pause the sender
      wait_drained();
      drain_pause = 1;
      repeat (20) @(posedge clock);
      drain_pause = 0;

      // random traffic: reuse from a small pool so hits are common
      for (int i = 0; i < 16; i++) pool[i] = rand_shape();
      for (int n = 0; n < 560; n++) begin
         pick = $urandom_range(0, 99);
         if (n == 450) begin
            wait_drained();
            no_idle = 1;
         end
         if (pick < 4) add_item(CMD_AGE, rand_shape());
         else if (pick < 30)
            add_item(cmd_type'($urandom_range(1, 3)), rand_shape());
         else
            add_item(cmd_type'($urandom_range(1, 3)), pool[$urandom_range(0, 15)]);
      end
      wait_drained();
      repeat (600) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // timeout
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/tsda_pkg.sv
rtl/tsda_cell.sv
rtl/tile_shape_dedup_allocator.sv
tb/sv/tb_tile_shape_dedup_allocator.sv
